@@ sv/mf3_pkg.sv @@
package mf3_pkg;

  // Field widths of the pixel and result items
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int ROWS_W = 12;
  localparam int COLS_W = 11;

  // Line store depth and its address width
  localparam int MAX_COLS = 1024;
  localparam int ADDR_W   = $clog2(MAX_COLS);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_IMAGE_ROWS = 1'b0;
  localparam logic REG_IMAGE_COLS = 1'b1;

  // Widths of the partial sums: three pixels, then nine pixels plus the rounding term
  localparam int CSUM_W = 10;
  localparam int SUM_W  = 12;

  // Rounding term and reciprocal of nine in 0.16 fixed point
  localparam logic [SUM_W-1:0] ROUND_ADD = 12'd4;
  localparam logic [12:0]      RECIP9    = 13'd7282;
  localparam int               PROD_W    = 24;
  localparam int               RECIP_SH  = 16;

  // Positions and flags of the up to four results caused by one pixel.
  // Slot k takes row candidate k[1] and column candidate k[0].
  typedef struct packed {
    logic [ROW_W-1:0] row_a;
    logic [ROW_W-1:0] row_b;
    logic [COL_W-1:0] col_a;
    logic [COL_W-1:0] col_b;
    logic [3:0]       mask;
    logic             frame_end;
  } res_meta_t;

endpackage

@@ sv/mf3_ifs.sv @@
// Pixel channel: one item per accepted pixel
interface mf3_pix_if import mf3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// Result channel: one item per filtered pixel
interface mf3_res_if import mf3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] mean_value;
  logic             run_last;
  logic             frame_done;

  modport source (output valid, output out_row, output out_col, output mean_value,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input mean_value,
                  input run_last, input frame_done, output ready);
endinterface

@@ sv/mean_filter_3x3_replicate_edges_top.sv @@
// Pipeline: an accepted pixel passes through stages B, C, D and E into the result register F.
// Throughput: one pixel per cycle while each pixel causes at most one result and the
// receiver is ready; the result register hands out one result per cycle while the
// receiver is ready, so a pixel causing several results can stall the input until
// its last result is taken (up to four results at the bottom right corner).
// Reset (synchronous, active low) clears the pipeline, position and windows and
// sets both size registers to one; the line store is not cleared.
module mean_filter_3x3_replicate_edges_top import mf3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mf3_pix_if.sink           in_px,
  mf3_res_if.source         out_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Picks which held row or column a window tap uses: the tap position is clamped
  // to the frame, then to the three held rows or columns ending at cur.
  function automatic logic [1:0] tap_sel(input logic signed [14:0] p,
                                         input logic signed [14:0] hi,
                                         input logic signed [14:0] cur);
    logic signed [14:0] t;
    t = p;
    if (t < 0) t = '0;
    if (t > hi) t = hi;
    t = t - cur + 15'sd2;
    if (t < 0) t = '0;
    if (t > 15'sd2) t = 15'sd2;
    return t[1:0];
  endfunction

  // Configuration registers
  logic [ROWS_W-1:0] cfg_rows_r;
  logic [COLS_W-1:0] cfg_cols_r;

  // Raster position of the next pixel
  logic [ROW_W-1:0] row_pos_r;
  logic [COL_W-1:0] col_pos_r;

  // Line store: older row in the upper byte, newer row in the lower byte
  logic [2*PIX_W-1:0] line_mem [MAX_COLS];
  logic [2*PIX_W-1:0] rd_data_r;
  logic               fwd_r;
  logic [2*PIX_W-1:0] fwd_data_r;

  // Three-by-three window: row 0 older, row 1 newer, row 2 current
  logic [PIX_W-1:0] win_r [3][3];

  // Pipeline valids and handshake
  logic b_valid_r, c_valid_r, d_valid_r, e_valid_r;
  logic rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
  logic in_acc, b_move, out_acc;

  // Stage B: the accepted pixel while its line store entry is read
  logic [ROW_W-1:0] b_i_r;
  logic [COL_W-1:0] b_j_r;
  logic [PIX_W-1:0] b_px_r;
  logic             b_last_row_r, b_last_col_r;
  logic [ROW_W-1:0] b_rows_m1_r;
  logic [COL_W-1:0] b_cols_m1_r;

  // Stages C to F
  res_meta_t        c_meta_r, d_meta_r, e_meta_r, f_meta_r;
  logic [1:0]       c_rs_r [2][3];
  logic [1:0]       c_cs_r [2][3];
  logic [1:0]       d_rs_r [2][3];
  logic [CSUM_W-1:0] d_colsum_r [3][2];
  logic [SUM_W-1:0] e_sum_r [4];
  logic [PIX_W-1:0] f_mean_r [4];
  logic [3:0]       f_mask_r;

  // Combinational next values
  logic [ROWS_W-1:0]  rows_eff;
  logic [COLS_W-1:0]  cols_eff;
  logic               in_last_row, in_last_col;
  logic [2*PIX_W-1:0] entry;
  logic [PIX_W-1:0]   po, pn;
  res_meta_t          meta_nxt;
  logic [1:0]         rs_nxt [2][3];
  logic [1:0]         cs_nxt [2][3];
  logic [CSUM_W-1:0]  colsum_nxt [3][2];
  logic [SUM_W-1:0]   sum_nxt [4];
  logic [PIX_W-1:0]   mean_nxt [4];
  logic [1:0]         out_sel;
  logic               out_single;
  logic [3:0]         f_mask_nxt;

  // APB register access
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_IMAGE_COLS) ? CFG_DW'(cfg_cols_r)
                                                       : CFG_DW'(cfg_rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= ROWS_W'(1);
      cfg_cols_r <= COLS_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[2])
        REG_IMAGE_ROWS: cfg_rows_r <= cfg_pwdata[ROWS_W-1:0];
        REG_IMAGE_COLS: cfg_cols_r <= cfg_pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size as used: zero counts as one, columns are capped at the store depth
  always_comb begin
    rows_eff = (cfg_rows_r == '0) ? ROWS_W'(1) : cfg_rows_r;
    if (cfg_cols_r == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cfg_cols_r > COLS_W'(MAX_COLS)) begin
      cols_eff = COLS_W'(MAX_COLS);
    end else begin
      cols_eff = cfg_cols_r;
    end
    in_last_row = ({1'b0, row_pos_r} + (ROW_W+1)'(1)) >= {1'b0, rows_eff};
    in_last_col = ({1'b0, col_pos_r} + (COL_W+1)'(1)) >= cols_eff;
  end

  // Ready chain; the result register frees when its last result is taken
  assign out_single = (f_mask_r & (f_mask_r - 4'd1)) == 4'd0;
  assign rdy_f  = (f_mask_r == 4'd0) || (out_res.ready && out_single);
  assign rdy_e  = !e_valid_r || rdy_f;
  assign rdy_d  = !d_valid_r || rdy_e;
  assign rdy_c  = !c_valid_r || rdy_d;
  assign rdy_b  = !b_valid_r || rdy_c;
  assign in_px.ready = rdy_b;
  assign in_acc = in_px.valid && rdy_b;
  assign b_move = b_valid_r && rdy_c;

  // Raster position advances on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (in_acc) begin
      if (in_last_col) begin
        col_pos_r <= '0;
        row_pos_r <= in_last_row ? '0 : row_pos_r + ROW_W'(1);
      end else begin
        col_pos_r <= col_pos_r + COL_W'(1);
      end
    end
  end

  // Line store entry of the pixel in stage B, forwarded when the item ahead of it
  // wrote the same column in the cycle of the read
  assign entry = fwd_r ? fwd_data_r : rd_data_r;
  assign po    = entry[2*PIX_W-1:PIX_W];
  assign pn    = entry[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= line_mem[col_pos_r];
    end
    if (b_move) begin
      line_mem[b_j_r] <= {pn, b_px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_acc) begin
      fwd_r <= b_move && (b_j_r == col_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_data_r <= {pn, b_px_r};
    end
  end

  // Valid bits of the pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      if (rdy_b) b_valid_r <= in_px.valid;
      if (rdy_c) c_valid_r <= b_valid_r;
      if (rdy_d) d_valid_r <= c_valid_r;
      if (rdy_e) e_valid_r <= d_valid_r;
    end
  end

  // Stage B capture of the accepted pixel and its position
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_i_r        <= row_pos_r;
      b_j_r        <= col_pos_r;
      b_px_r       <= in_px.pixel_in;
      b_last_row_r <= in_last_row;
      b_last_col_r <= in_last_col;
      b_rows_m1_r  <= rows_eff - ROWS_W'(1);
      b_cols_m1_r  <= COL_W'(cols_eff - COLS_W'(1));
    end
  end

  // Result positions and tap selection of the pixel in stage B
  always_comb begin
    meta_nxt.row_a     = b_i_r - ROW_W'(1);
    meta_nxt.row_b     = b_i_r;
    meta_nxt.col_a     = b_j_r - COL_W'(1);
    meta_nxt.col_b     = b_j_r;
    meta_nxt.mask[0]   = (b_i_r != '0) && (b_j_r != '0);
    meta_nxt.mask[1]   = (b_i_r != '0) && b_last_col_r;
    meta_nxt.mask[2]   = b_last_row_r && (b_j_r != '0);
    meta_nxt.mask[3]   = b_last_row_r && b_last_col_r;
    meta_nxt.frame_end = b_last_row_r && b_last_col_r;
    for (int a = 0; a < 2; a++) begin
      for (int d = 0; d < 3; d++) begin
        rs_nxt[a][d] = tap_sel(15'(b_i_r) + 15'(a + d) - 15'd2, 15'(b_rows_m1_r),
                               15'(b_i_r));
        cs_nxt[a][d] = tap_sel(15'(b_j_r) + 15'(a + d) - 15'd2, 15'(b_cols_m1_r),
                               15'(b_j_r));
      end
    end
  end

  // Window shift as the pixel leaves stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < 3; w++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[w][k] <= '0;
        end
      end
    end else if (b_move) begin
      for (int w = 0; w < 3; w++) begin
        win_r[w][0] <= win_r[w][1];
        win_r[w][1] <= win_r[w][2];
      end
      win_r[0][2] <= po;
      win_r[1][2] <= pn;
      win_r[2][2] <= b_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_meta_r <= meta_nxt;
      c_rs_r   <= rs_nxt;
      c_cs_r   <= cs_nxt;
    end
  end

  // Stage C: three-tap sums along each held row for both column candidates
  always_comb begin
    for (int w = 0; w < 3; w++) begin
      for (int b = 0; b < 2; b++) begin
        colsum_nxt[w][b] = CSUM_W'(win_r[w][c_cs_r[b][0]]) +
                           CSUM_W'(win_r[w][c_cs_r[b][1]]) +
                           CSUM_W'(win_r[w][c_cs_r[b][2]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid_r && rdy_d) begin
      d_meta_r   <= c_meta_r;
      d_rs_r     <= c_rs_r;
      d_colsum_r <= colsum_nxt;
    end
  end

  // Stage D: nine-pixel sum of each result plus the rounding term
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        sum_nxt[a*2+b] = SUM_W'(d_colsum_r[d_rs_r[a][0]][b]) +
                         SUM_W'(d_colsum_r[d_rs_r[a][1]][b]) +
                         SUM_W'(d_colsum_r[d_rs_r[a][2]][b]) + ROUND_ADD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid_r && rdy_e) begin
      e_meta_r <= d_meta_r;
      e_sum_r  <= sum_nxt;
    end
  end

  // Stage E: division by nine as a multiplication by its reciprocal
  always_comb begin
    logic [PROD_W-1:0] prod;
    prod = '0;
    for (int k = 0; k < 4; k++) begin
      prod        = PROD_W'(e_sum_r[k]) * PROD_W'(RECIP9);
      mean_nxt[k] = prod[RECIP_SH +: PIX_W];
    end
  end

  // Result register: hands out the remaining results of one pixel in order
  always_comb begin
    if (f_mask_r[0]) begin
      out_sel = 2'd0;
    end else if (f_mask_r[1]) begin
      out_sel = 2'd1;
    end else if (f_mask_r[2]) begin
      out_sel = 2'd2;
    end else begin
      out_sel = 2'd3;
    end
    out_acc = out_res.valid && out_res.ready;
    if (rdy_f) begin
      f_mask_nxt = e_valid_r ? e_meta_r.mask : 4'd0;
    end else if (out_acc) begin
      f_mask_nxt = f_mask_r & ~(4'd1 << out_sel);
    end else begin
      f_mask_nxt = f_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_mask_r <= '0;
    end else begin
      f_mask_r <= f_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid_r && rdy_f) begin
      f_meta_r <= e_meta_r;
      f_mean_r <= mean_nxt;
    end
  end

  assign out_res.valid      = f_mask_r != 4'd0;
  assign out_res.out_row    = out_sel[1] ? f_meta_r.row_b : f_meta_r.row_a;
  assign out_res.out_col    = out_sel[0] ? f_meta_r.col_b : f_meta_r.col_a;
  assign out_res.mean_value = f_mean_r[out_sel];
  assign out_res.run_last   = out_single;
  assign out_res.frame_done = out_single && f_meta_r.frame_end;

endmodule

@@ sv/mf3_checker.sv @@
// Port-level checks of the result channel
module mf3_checker import mf3_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_row,
  input logic [COL_W-1:0] out_col,
  input logic [PIX_W-1:0] mean_value,
  input logic             run_last,
  input logic             frame_done
);

  // A result that is not taken stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A result that is not taken keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({out_row, out_col, mean_value, run_last, frame_done}))
    else $error("result payload changed while stalled");

  // The final result of a frame is also the last result of its pixel
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> run_last)
    else $error("frame end flagged on a result that is not the last of its item");

  // Reset leaves no result on offer
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind mean_filter_3x3_replicate_edges_top mf3_checker u_mf3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_row    (out_res.out_row),
  .out_col    (out_res.out_col),
  .mean_value (out_res.mean_value),
  .run_last   (out_res.run_last),
  .frame_done (out_res.frame_done)
);

@@ bench/tb_mean_filter_3x3_replicate_edges_top.sv @@
module tb_mean_filter_3x3_replicate_edges_top;
  import mf3_pkg::*;

  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_ITEMS    = 65;

  // One filtered pixel as the block should report it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] mean;
    logic             run_last;
    logic             frame_done;
  } mean_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  mf3_pix_if pix_ch ();
  mf3_res_if res_ch ();

  mean_filter_3x3_replicate_edges_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (pix_ch),
    .out_res    (res_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Filter state as the bench sees it: frame size, the two previous rows,
  // the 3x3 tap window (older row, newer row, current row) and the position.
  logic [ROWS_W-1:0] rows_setting;
  logic [COLS_W-1:0] cols_setting;
  logic [PIX_W-1:0]  line_older [MAX_COLS];
  logic [PIX_W-1:0]  line_newer [MAX_COLS];
  logic [PIX_W-1:0]  taps [3][3];
  int                next_row;
  int                next_col;

  mean_result_t pending_means [$];
  int           fail_count;
  bit           idling_on;
  bit           hold_off_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_to(input int x, input int lo, input int hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Sum of the clamped 3x3 neighbourhood of (r,c), taken from the held taps
  // while the pixel at (i,j) is the newest one.
  function automatic int window_sum(input int r, input int c, input int i, input int j,
                                    input int rows, input int cols);
    int sum, rs, cs, dr, dc;
    sum = 0;
    for (dr = -1; dr <= 1; dr++) begin
      rs = clamp_to(clamp_to(r + dr, 0, rows - 1) - i + 2, 0, 2);
      for (dc = -1; dc <= 1; dc++) begin
        cs = clamp_to(clamp_to(c + dc, 0, cols - 1) - j + 2, 0, 2);
        sum += int'(taps[rs][cs]);
      end
    end
    return sum;
  endfunction

  // Advances the filter state by one pixel and queues every mean it releases.
  function automatic void filter_pixel(input logic [PIX_W-1:0] px);
    int rows, cols, i, j, nr, nc, a, b, k;
    int row_cand [2];
    int col_cand [2];
    bit last_r, last_c;
    logic [PIX_W-1:0] above2, above1;
    mean_result_t res;
    rows = (rows_setting == 0) ? 1 : int'(rows_setting);
    cols = (cols_setting == 0) ? 1 : int'(cols_setting);
    if (cols > MAX_COLS) cols = MAX_COLS;
    i = next_row;
    j = next_col;
    last_r = (i + 1 >= rows);
    last_c = (j + 1 >= cols);

    above2 = line_older[j];
    above1 = line_newer[j];
    line_older[j] = above1;
    line_newer[j] = px;
    for (k = 0; k < 3; k++) begin
      taps[k][0] = taps[k][1];
      taps[k][1] = taps[k][2];
    end
    taps[0][2] = above2;
    taps[1][2] = above1;
    taps[2][2] = px;

    // Windows completed by this pixel, in row then column order
    nr = 0;
    nc = 0;
    if (i >= 1) begin
      row_cand[nr] = i - 1;
      nr++;
    end
    if (last_r) begin
      row_cand[nr] = i;
      nr++;
    end
    if (j >= 1) begin
      col_cand[nc] = j - 1;
      nc++;
    end
    if (last_c) begin
      col_cand[nc] = j;
      nc++;
    end
    for (a = 0; a < nr; a++) begin
      for (b = 0; b < nc; b++) begin
        res.row        = ROW_W'(row_cand[a]);
        res.col        = COL_W'(col_cand[b]);
        res.mean       = PIX_W'((window_sum(row_cand[a], col_cand[b], i, j, rows, cols)
                                 + 4) / 9);
        res.run_last   = (a == nr - 1) && (b == nc - 1);
        res.frame_done = res.run_last && last_r && last_c;
        pending_means.push_back(res);
      end
    end

    if (last_c) begin
      next_col = 0;
      next_row = last_r ? 0 : i + 1;
    end else begin
      next_col = j + 1;
    end
  endfunction

  // Every accepted pixel goes through the predictor.
  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      filter_pixel(pix_ch.pixel_in);
    end
  end

  task automatic check_field(input string field, input logic [31:0] expected_val,
                             input logic [31:0] actual_val);
    if (actual_val !== expected_val) begin
      $error("%s mismatch: expected %0d, actual %0d", field, expected_val, actual_val);
      fail_count++;
    end
  endtask

  // Each accepted result is compared with the oldest outstanding mean.
  always @(posedge clk) begin : result_check
    mean_result_t exp_res;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_means.size() == 0) begin
        $error("result at row %0d col %0d arrived with none expected",
               res_ch.out_row, res_ch.out_col);
        fail_count++;
      end else begin
        exp_res = pending_means.pop_front();
        check_field("out_row", 32'(exp_res.row), 32'(res_ch.out_row));
        check_field("out_col", 32'(exp_res.col), 32'(res_ch.out_col));
        check_field("mean_value", 32'(exp_res.mean), 32'(res_ch.mean_value));
        check_field("run_last", 32'(exp_res.run_last), 32'(res_ch.run_last));
        check_field("frame_done", 32'(exp_res.frame_done), 32'(res_ch.frame_done));
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin : result_receiver
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one pixel, sometimes after a gap, and returns once it is accepted.
  // Valid stays high afterwards so that back-to-back items need no toggle.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Stops offering pixels and waits until every mean has come back and the
  // pipeline has had time to finish pixels that release nothing.
  task automatic wait_idle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(reg_idx) << 2;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (reg_idx == REG_IMAGE_ROWS) begin
      rows_setting = value[ROWS_W-1:0];
    end else begin
      cols_setting = value[COLS_W-1:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_frame_size(input int rows_val, input int cols_val);
    wait_idle();
    write_reg(REG_IMAGE_ROWS, CFG_DW'(rows_val));
    write_reg(REG_IMAGE_COLS, CFG_DW'(cols_val));
  endtask

  // Sends one whole frame of the current size; a quarter of the pixels sit
  // at the extremes of the range.
  task automatic send_frame(output int count);
    int rows, cols;
    rows = (rows_setting == 0) ? 1 : int'(rows_setting);
    cols = (cols_setting == 0) ? 1 : int'(cols_setting);
    if (cols > MAX_COLS) cols = MAX_COLS;
    count = rows * cols;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
      end else begin
        send_pixel(PIX_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Small frames with extreme pixels, single pixel frames, zero sizes and a
  // one-column frame.
  task automatic test_corner_cases();
    logic [PIX_W-1:0] mixed_px [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                                       8'd255, 8'd0, 8'd0, 8'd255};
    logic [PIX_W-1:0] column_px [3] = '{8'd0, 8'd255, 8'd7};
    set_frame_size(3, 3);
    foreach (mixed_px[k]) send_pixel(mixed_px[k]);
    set_frame_size(1, 1);
    send_pixel(8'd255);
    // A size register of zero behaves as one.
    set_frame_size(0, 0);
    send_pixel(8'd128);
    set_frame_size(3, 1);
    foreach (column_px[k]) send_pixel(column_px[k]);
    set_frame_size(2, 4);
    repeat (8) send_pixel(8'd255);
  endtask

  // Shrinks the frame while the position lies beyond the new last row and
  // column, so the next pixel closes the frame with four results.
  task automatic test_mid_frame_resize();
    set_frame_size(4, 6);
    repeat (9) send_pixel(PIX_W'($urandom_range(0, 255)));
    set_frame_size(1, 2);
    send_pixel(PIX_W'($urandom_range(0, 255)));
    repeat (2) send_pixel(PIX_W'($urandom_range(0, 255)));
    set_frame_size(3, 2);
    repeat (6) send_pixel(PIX_W'($urandom_range(0, 255)));
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so
  // the block fills and stalls its input.
  task automatic test_stalled_receiver();
    int count;
    set_frame_size(3, 5);
    hold_off_req = 1'b1;
    send_frame(count);
  endtask

  // Whole frames of random small sizes with random content.
  task automatic test_random_frames();
    int sent, count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_frame_size($urandom_range(0, 6), $urandom_range(0, 9));
      send_frame(count);
      sent += count;
    end
  endtask

  // Largest size registers, including a column count above the line store
  // depth; the frame is then shrunk mid-row so that it closes after two rows.
  task automatic test_size_extremes();
    set_frame_size(4095, 2047);
    repeat (6) send_pixel(PIX_W'($urandom_range(0, 255)));
    set_frame_size(2, 3);
    repeat (4) send_pixel(PIX_W'($urandom_range(0, 255)));
    set_frame_size(0, 0);
    send_pixel(8'd255);
  endtask

  initial begin
    rst_n           = 1'b0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    fail_count      = 0;
    idling_on       = 1'b1;
    hold_off_req    = 1'b0;

    // Predictor starts from the reset state of the block, with its line copies also zeroed.
    rows_setting = ROWS_W'(1);
    cols_setting = COLS_W'(1);
    next_row     = 0;
    next_col     = 0;
    foreach (line_older[k]) begin
      line_older[k] = '0;
      line_newer[k] = '0;
    end
    foreach (taps[r, c]) taps[r][c] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_cases();
    test_mid_frame_resize();
    test_stalled_receiver();
    test_random_frames();
    // The last part runs at full rate on both sides.
    idling_on = 1'b0;
    test_size_extremes();
    wait_idle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mf3_pkg.sv
sv/mf3_ifs.sv
sv/mean_filter_3x3_replicate_edges_top.sv
sv/mf3_checker.sv
bench/tb_mean_filter_3x3_replicate_edges_top.sv
